### rtl/breath_detect_integrator_top_macros.svh
// Assertion helpers shared by the breath detector modules.
// Each helper expects signals named clk and rst_n in the module that uses it.
`ifndef BREATH_DETECT_INTEGRATOR_TOP_MACROS_SVH
`define BREATH_DETECT_INTEGRATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("breath detector check failed");

// The consequent must hold in the cycle after the antecedent.
`define BDI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("breath detector check failed");

`endif

### rtl/bdi_pkg.sv
package bdi_pkg;

  // Field widths.
  localparam int P_W        = 15;
  localparam int IN_W       = 16;
  localparam int ROOT_W     = 12;
  localparam int ERR_W      = 16;
  localparam int OUT_SUM_W  = 32;
  localparam int OUT_INT_W  = 24;
  localparam int HIST_DEPTH = 4;

  // Square root unit: radicand is the code shifted up by eight bits.
  localparam int RAD_W      = P_W + 8;
  localparam int ROOT_STEPS = 12;
  localparam int STEP_W     = 4;

  localparam logic [P_W-1:0]   THRESH_RESET = P_W'(64);
  localparam logic [ERR_W-1:0] ERR_MAX      = 16'hFFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic root_start;
    logic commit;
  } bdi_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic root_busy;
  } bdi_stat_t;

endpackage

### rtl/breath_detect_integrator_top.sv
// Breath detector and square-root integrator. Each input word carries one
// differential-pressure sample (1/64 Pa per step) and a read-ok flag, and
// produces exactly one result word. A good read goes from acceptance through
// the bit-serial square root unit (twelve root bits, one root bit per cycle),
// a state in which the controller sees the unit finish, and the commit state.
// A failed read skips the root unit and goes from acceptance straight to the
// commit state. The next word is accepted in the cycle after commit, and not
// before, while the previous result may still be waiting on the output; a
// commit waits only while the output register is full and stalled. The
// threshold register may be written only while no word is in flight.
module breath_detect_integrator_top
  import bdi_pkg::*;
#(
  parameter int SUM_BITS   = 32,
  parameter int COUNT_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [IN_W-1:0]      in_pressure,
  input  logic                 in_read_ok,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_breath_start,
  output logic                 out_breath_end,
  output logic                 out_integrating,
  output logic [OUT_SUM_W-1:0] out_breath_sum,
  output logic [OUT_INT_W-1:0] out_last_interval,
  output logic [ERR_W-1:0]     out_error_count,
  input  logic                 cfg_wr_en,
  input  logic [P_W-1:0]       cfg_wr_data
);

  bdi_cmd_t          cmd;
  bdi_stat_t         stat;
  logic [ROOT_W-1:0] root;
  logic [P_W-1:0]    root_code;
  logic              root_busy;

  assign stat.root_busy = root_busy;

  bdi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_read_ok (in_read_ok),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  bdi_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.root_start),
    .code  (root_code),
    .busy  (root_busy),
    .root  (root)
  );

  bdi_dp #(
    .SUM_BITS   (SUM_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_pressure       (in_pressure),
    .in_read_ok        (in_read_ok),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .root              (root),
    .root_code         (root_code),
    .out_breath_start  (out_breath_start),
    .out_breath_end    (out_breath_end),
    .out_integrating   (out_integrating),
    .out_breath_sum    (out_breath_sum),
    .out_last_interval (out_last_interval),
    .out_error_count   (out_error_count)
  );

endmodule

### rtl/bdi_sqrt.sv
module bdi_sqrt
  import bdi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [P_W-1:0]    code,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]  rem_r, rem_nxt;
  logic [RAD_W:0]    res_r, res_nxt;
  logic [RAD_W-1:0]  bit_r, bit_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic [RAD_W+1:0]  trial;

  // One result bit per cycle: compare the remainder with res + bit.
  always_comb begin
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    trial    = {1'b0, res_r} + (RAD_W+2)'(bit_r);
    if (start) begin
      rem_nxt  = {code, 8'd0};
      res_nxt  = '0;
      bit_nxt  = RAD_W'(1) << (RAD_W - 1);
      step_nxt = STEP_W'(ROOT_STEPS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ({2'b00, rem_r} >= trial) begin
        rem_nxt = rem_r - RAD_W'(trial);
        res_nxt = (res_r >> 1) + (RAD_W+1)'(bit_r);
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign busy = busy_r;
  assign root = res_r[ROOT_W-1:0];

endmodule

### rtl/bdi_ctrl.sv
`include "breath_detect_integrator_top_macros.svh"

module bdi_ctrl
  import bdi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_read_ok,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  bdi_stat_t stat,
  output bdi_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROOT,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_take;
  logic   out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Sequencing: take a word, run the root unit on good reads, then commit.
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    out_valid_nxt  = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          cmd.load       = 1'b1;
          cmd.root_start = in_read_ok;
          state_nxt      = in_read_ok ? S_ROOT : S_COMMIT;
        end
      end
      S_ROOT: begin
        if (!stat.root_busy) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `BDI_ASSERT_NOW(a_commit_slot_free, cmd.commit, !out_valid_r || !out_stall)
  `BDI_ASSERT_NEXT(a_commit_shows_word, cmd.commit, out_valid)
  `BDI_ASSERT_NEXT(a_good_read_runs_root, in_take && in_read_ok, stat.root_busy)

endmodule

### rtl/bdi_dp.sv
`include "breath_detect_integrator_top_macros.svh"

module bdi_dp
  import bdi_pkg::*;
#(
  parameter int SUM_BITS   = 32,
  parameter int COUNT_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bdi_cmd_t             cmd,
  input  logic [IN_W-1:0]      in_pressure,
  input  logic                 in_read_ok,
  input  logic                 cfg_wr_en,
  input  logic [P_W-1:0]       cfg_wr_data,
  input  logic [ROOT_W-1:0]    root,
  output logic [P_W-1:0]       root_code,
  output logic                 out_breath_start,
  output logic                 out_breath_end,
  output logic                 out_integrating,
  output logic [OUT_SUM_W-1:0] out_breath_sum,
  output logic [OUT_INT_W-1:0] out_last_interval,
  output logic [ERR_W-1:0]     out_error_count
);

  logic [P_W-1:0]        th_r;
  logic [P_W-1:0]        code_r;
  logic                  ok_r;
  logic [P_W-1:0]        ph_r [HIST_DEPTH];
  logic [ROOT_W-1:0]     rh_r [HIST_DEPTH];
  logic                  in_breath_r, in_breath_nxt;
  logic [SUM_BITS-1:0]   sum_r, sum_nxt, seed;
  logic [SUM_BITS:0]     acc;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [COUNT_BITS-1:0] lat_r, lat_nxt;
  logic [ERR_W-1:0]      fail_r, fail_nxt;
  logic [P_W-1:0]        new_code;
  logic [ROOT_W-1:0]     new_root;
  logic                  above, below, start_c, end_c;
  logic [OUT_SUM_W-1:0]  sum_sat;
  logic [OUT_INT_W-1:0]  lat_sat;

  // Negative samples clamp to zero on entry.
  assign root_code = in_pressure[IN_W-1] ? '0 : in_pressure[P_W-1:0];

  // Breath decisions and state updates for the word being committed.
  always_comb begin
    cnt_inc  = (&cnt_r) ? cnt_r : cnt_r + COUNT_BITS'(1);
    new_code = ok_r ? code_r : ph_r[0];
    new_root = ok_r ? root : rh_r[0];
    above    = ok_r && (code_r >= th_r) && (ph_r[0] >= th_r) && (ph_r[1] >= th_r);
    below    = ok_r && (code_r <= th_r) && (ph_r[0] <= th_r) && (ph_r[1] <= th_r);
    start_c  = above && !in_breath_r;
    end_c    = below && in_breath_r;
    seed     = SUM_BITS'(rh_r[0]) + SUM_BITS'(rh_r[1]) + SUM_BITS'(rh_r[2])
             + SUM_BITS'(root);
    acc      = {1'b0, sum_r} + (SUM_BITS+1)'(root);
    sum_nxt  = sum_r;
    if (start_c) begin
      sum_nxt = seed;
    end else if (ok_r && in_breath_r) begin
      sum_nxt = acc[SUM_BITS] ? '1 : acc[SUM_BITS-1:0];
    end
    in_breath_nxt = start_c ? 1'b1 : (end_c ? 1'b0 : in_breath_r);
    cnt_nxt       = start_c ? '0 : cnt_inc;
    lat_nxt       = start_c ? cnt_inc : lat_r;
    fail_nxt      = (!ok_r && (fail_r != ERR_MAX)) ? fail_r + ERR_W'(1) : fail_r;
  end

  // Saturate the sum to the output width.
  generate
    if (SUM_BITS > OUT_SUM_W) begin : g_sum_wide
      assign sum_sat = (|sum_nxt[SUM_BITS-1:OUT_SUM_W]) ? '1 : sum_nxt[OUT_SUM_W-1:0];
    end else if (SUM_BITS == OUT_SUM_W) begin : g_sum_same
      assign sum_sat = sum_nxt;
    end else begin : g_sum_narrow
      assign sum_sat = {{(OUT_SUM_W-SUM_BITS){1'b0}}, sum_nxt};
    end
  endgenerate

  // Saturate the latched interval to the output width.
  generate
    if (COUNT_BITS > OUT_INT_W) begin : g_int_wide
      assign lat_sat = (|lat_nxt[COUNT_BITS-1:OUT_INT_W]) ? '1 : lat_nxt[OUT_INT_W-1:0];
    end else if (COUNT_BITS == OUT_INT_W) begin : g_int_same
      assign lat_sat = lat_nxt;
    end else begin : g_int_narrow
      assign lat_sat = {{(OUT_INT_W-COUNT_BITS){1'b0}}, lat_nxt};
    end
  endgenerate

  // Input capture and the threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      th_r <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      th_r <= cfg_wr_data;
    end
    if (cmd.load) begin
      code_r <= root_code;
      ok_r   <= in_read_ok;
    end
  end

  // Breath state, committed once per word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        ph_r[i] <= '0;
        rh_r[i] <= '0;
      end
      in_breath_r      <= 1'b0;
      sum_r            <= '0;
      cnt_r            <= '0;
      lat_r            <= '0;
      fail_r           <= '0;
      out_breath_start <= 1'b0;
      out_breath_end   <= 1'b0;
      out_integrating  <= 1'b0;
    end else if (cmd.commit) begin
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
        ph_r[i] <= ph_r[i-1];
        rh_r[i] <= rh_r[i-1];
      end
      ph_r[0]          <= new_code;
      rh_r[0]          <= new_root;
      in_breath_r      <= in_breath_nxt;
      sum_r            <= sum_nxt;
      cnt_r            <= cnt_nxt;
      lat_r            <= lat_nxt;
      fail_r           <= fail_nxt;
      out_breath_start <= start_c;
      out_breath_end   <= end_c;
      out_integrating  <= in_breath_nxt;
    end
  end

  // Result word payload.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_breath_sum    <= sum_sat;
      out_last_interval <= lat_sat;
      out_error_count   <= fail_nxt;
    end
  end

  `BDI_ASSERT_NOW(a_start_integrates, out_breath_start, out_integrating)
  `BDI_ASSERT_NOW(a_end_stops, out_breath_end, !out_integrating && !out_breath_start)
  `BDI_ASSERT_NEXT(a_fail_only_on_commit, !cmd.commit, $stable(fail_r))

endmodule

### test/breath_detect_integrator_checker.sv
// Watches both channels of the breath detector, predicts each result word
// from the accepted input words, and compares field by field.
module breath_detect_integrator_checker
  import bdi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [IN_W-1:0]      in_pressure,
  input  logic                 in_read_ok,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_breath_start,
  input  logic                 out_breath_end,
  input  logic                 out_integrating,
  input  logic [OUT_SUM_W-1:0] out_breath_sum,
  input  logic [OUT_INT_W-1:0] out_last_interval,
  input  logic [ERR_W-1:0]     out_error_count,
  input  logic                 cfg_wr_en,
  input  logic [P_W-1:0]       cfg_wr_data,
  output int                   mismatch_count,
  output int                   words_waiting,
  output int                   words_taken,
  output int                   words_checked,
  output int                   breaths_started,
  output int                   breaths_ended
);

  localparam longint unsigned SUM_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic                 started;
    logic                 ended;
    logic                 active;
    logic [OUT_SUM_W-1:0] total;
    logic [OUT_INT_W-1:0] interval;
    logic [ERR_W-1:0]     fails;
  } breath_word_t;

  // Shadow of the detector state.
  logic [P_W-1:0]       level;
  logic [P_W-1:0]       code_hist [HIST_DEPTH];
  logic [ROOT_W-1:0]    root_hist [HIST_DEPTH];
  logic                 breathing;
  logic [OUT_SUM_W-1:0] root_total;
  logic [OUT_INT_W-1:0] since_start;
  logic [OUT_INT_W-1:0] interval_held;
  logic [ERR_W-1:0]     read_failures;

  breath_word_t expected_words [$];
  int           errs_seen;
  int           taken;
  int           checked;
  int           starts;
  int           ends;

  // Integer square root found one bit at a time from the top.
  function automatic logic [ROOT_W-1:0] root_of(input logic [P_W-1:0] code);
    int unsigned radicand;
    int unsigned r;
    int unsigned trial;
    radicand = 32'({code, 8'h00});
    r = 0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = r | (32'd1 << b);
      if (trial * trial <= radicand) r = trial;
    end
    return ROOT_W'(r);
  endfunction

  // Advances the shadow state by one sample and returns the word it yields.
  function automatic breath_word_t predict_breath(input logic [IN_W-1:0] sample,
                                                  input logic ok);
    breath_word_t   w;
    logic [P_W-1:0] code;
    longint unsigned acc;
    w = '0;
    for (int i = HIST_DEPTH - 1; i > 0; i--) begin
      code_hist[i] = code_hist[i-1];
      root_hist[i] = root_hist[i-1];
    end
    if (since_start != '1) since_start = since_start + 1'b1;

    if (!ok) begin
      // The newest entry stays, so the shifted history repeats it.
      if (read_failures != ERR_MAX) read_failures = read_failures + 1'b1;
    end else begin
      code = in_pressure_clamp(sample);
      code_hist[0] = code;
      root_hist[0] = root_of(code);
      if (breathing) begin
        acc = 64'(root_total) + 64'(root_hist[0]);
        root_total = (acc > SUM_MAX) ? OUT_SUM_W'(SUM_MAX) : OUT_SUM_W'(acc);
        if (code_hist[0] <= level && code_hist[1] <= level && code_hist[2] <= level) begin
          breathing = 1'b0;
          w.ended = 1'b1;
        end
      end else if (code_hist[0] >= level && code_hist[1] >= level &&
                   code_hist[2] >= level) begin
        // The new breath is seeded with the roots of the whole history.
        root_total = 32'(root_hist[0]) + 32'(root_hist[1]) +
                     32'(root_hist[2]) + 32'(root_hist[3]);
        interval_held = since_start;
        since_start = '0;
        breathing = 1'b1;
        w.started = 1'b1;
      end
    end

    w.active = breathing;
    w.total = root_total;
    w.interval = interval_held;
    w.fails = read_failures;
    return w;
  endfunction

  // Negative samples count as no pressure at all.
  function automatic logic [P_W-1:0] in_pressure_clamp(input logic [IN_W-1:0] sample);
    return sample[IN_W-1] ? '0 : sample[P_W-1:0];
  endfunction

  task automatic report(input string field, input longint unsigned want,
                        input longint unsigned got);
    $display("mismatch on word %0d, %s: expected %0d, got %0d", checked, field, want, got);
    errs_seen++;
  endtask

  // Reset, register writes, predictions and comparisons all happen at the edge.
  always @(posedge clk) begin
    breath_word_t want;
    if (!rst_n) begin
      level = THRESH_RESET;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        code_hist[i] = '0;
        root_hist[i] = '0;
      end
      breathing = 1'b0;
      root_total = '0;
      since_start = '0;
      interval_held = '0;
      read_failures = '0;
      expected_words.delete();
    end else begin
      if (cfg_wr_en) level = cfg_wr_data;

      if (in_valid && !in_stall) begin
        expected_words.push_back(predict_breath(in_pressure, in_read_ok));
        taken++;
      end

      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report("word with nothing expected", 64'd0, 64'd1);
        end else begin
          want = expected_words.pop_front();
          if (out_breath_start !== want.started)
            report("breath_start", 64'(want.started), 64'(out_breath_start));
          if (out_breath_end !== want.ended)
            report("breath_end", 64'(want.ended), 64'(out_breath_end));
          if (out_integrating !== want.active)
            report("integrating", 64'(want.active), 64'(out_integrating));
          if (out_breath_sum !== want.total)
            report("breath_sum", 64'(want.total), 64'(out_breath_sum));
          if (out_last_interval !== want.interval)
            report("last_interval", 64'(want.interval), 64'(out_last_interval));
          if (out_error_count !== want.fails)
            report("error_count", 64'(want.fails), 64'(out_error_count));
          if (want.started) starts++;
          if (want.ended) ends++;
        end
        checked++;
      end
    end

    // Counts are published after the edge so readers see settled values.
    mismatch_count  <= errs_seen;
    words_waiting   <= expected_words.size();
    words_taken     <= taken;
    words_checked   <= checked;
    breaths_started <= starts;
    breaths_ended   <= ends;
  end

endmodule

### test/breath_detect_integrator_top_tb.sv
// Drives sample words into the breath detector under random gaps and output
// stalls, steps the threshold through several levels, and gives the verdict.
module breath_detect_integrator_top_tb;
  import bdi_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 147;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid;
  logic                 in_stall;
  logic [IN_W-1:0]      in_pressure;
  logic                 in_read_ok;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_breath_start;
  logic                 out_breath_end;
  logic                 out_integrating;
  logic [OUT_SUM_W-1:0] out_breath_sum;
  logic [OUT_INT_W-1:0] out_last_interval;
  logic [ERR_W-1:0]     out_error_count;
  logic                 cfg_wr_en;
  logic [P_W-1:0]       cfg_wr_data;

  int  mismatch_count;
  int  words_waiting;
  int  words_taken;
  int  words_checked;
  int  breaths_started;
  int  breaths_ended;
  int  cycles = 0;
  int  levels_used = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;

  always #6 clk = ~clk;

  breath_detect_integrator_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pressure      (in_pressure),
    .in_read_ok       (in_read_ok),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_breath_start (out_breath_start),
    .out_breath_end   (out_breath_end),
    .out_integrating  (out_integrating),
    .out_breath_sum   (out_breath_sum),
    .out_last_interval(out_last_interval),
    .out_error_count  (out_error_count),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  breath_detect_integrator_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pressure      (in_pressure),
    .in_read_ok       (in_read_ok),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_breath_start (out_breath_start),
    .out_breath_end   (out_breath_end),
    .out_integrating  (out_integrating),
    .out_breath_sum   (out_breath_sum),
    .out_last_interval(out_last_interval),
    .out_error_count  (out_error_count),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .mismatch_count   (mismatch_count),
    .words_waiting    (words_waiting),
    .words_taken      (words_taken),
    .words_checked    (words_checked),
    .breaths_started  (breaths_started),
    .breaths_ended    (breaths_ended)
  );

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d words outstanding", cycles, words_waiting);
      $display("breath_detect_integrator_top_tb NOT OK");
      $finish;
    end
  end

  // Result side: a random stall before each word, none in calm stretches.
  initial begin
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = rx_calm ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid || out_stall) @(posedge clk);
    end
  end

  // Sends one word after a random gap and returns at the edge that takes it.
  task automatic send_word(input logic [IN_W-1:0] pressure, input logic ok);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_pressure <= pressure;
    in_read_ok  <= ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops sending and waits until every result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_level(input logic [P_W-1:0] lvl);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lvl;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    levels_used++;
  endtask

  // Random words in runs above and below the threshold so that breaths
  // start and end often, with failed reads and arbitrary noise mixed in.
  task automatic run_phase(input logic [P_W-1:0] lvl, input bit drain_midway);
    int              run_left;
    int              kind;
    int              pick;
    logic [IN_W-1:0] p;
    logic            ok;
    run_left = 0;
    kind = 0;
    for (int n = 0; n < PHASE_WORDS; n++) begin
      tx_calm = ((n / 40) % 3) == 2;
      rx_calm = ((n / 55) % 3) == 1;
      if (drain_midway && n == PHASE_WORDS / 2) settle();
      if (run_left == 0) begin
        pick = $urandom_range(0, 9);
        kind = (pick < 4) ? 0 : (pick < 8) ? 1 : 2;
        run_left = (kind == 2) ? $urandom_range(1, 3) : $urandom_range(2, 10);
      end
      run_left--;
      ok = ($urandom_range(0, 11) != 0);
      pick = $urandom_range(0, 3);
      if (!ok || kind == 2) begin
        p = IN_W'($urandom);
      end else if (kind == 0) begin
        p = (pick == 0) ? IN_W'(lvl) : IN_W'($urandom_range(int'(lvl), 32767));
      end else begin
        if (pick == 0) p = IN_W'(lvl);
        else if (pick == 1) p = {1'b1, P_W'($urandom)};
        else p = IN_W'($urandom_range(0, int'(lvl)));
      end
      send_word(p, ok);
    end
    settle();
  endtask

  // Stimulus: directed words at the reset threshold, then random phases.
  initial begin
    in_valid    = 1'b0;
    in_pressure = '0;
    in_read_ok  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Three samples exactly at the threshold start a breath.
    send_word(16'h0040, 1'b1);
    send_word(16'h0040, 1'b1);
    send_word(16'h0040, 1'b1);
    // Full-scale sample, then a failed read in the middle of the breath.
    send_word(16'h7FFF, 1'b1);
    send_word(16'hFFFF, 1'b0);
    // Most negative sample clamps to zero; the breath ends on the -1 sample that follows.
    send_word(16'h8000, 1'b1);
    send_word(16'h0040, 1'b1);
    send_word(16'hFFFF, 1'b1);
    // Failed reads while idle.
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b0);
    // Two above then one below: no start.
    send_word(16'h0041, 1'b1);
    send_word(16'h0041, 1'b1);
    send_word(16'h003F, 1'b1);
    send_word(16'h0041, 1'b1);
    send_word(16'h0041, 1'b1);
    send_word(16'h0041, 1'b1);
    send_word(16'h003F, 1'b1);
    send_word(16'h0040, 1'b1);
    send_word(16'h0000, 1'b1);
    send_word(16'h0001, 1'b1);
    send_word(16'h0000, 1'b1);
    settle();

    // Threshold extremes, small and random levels, and the reset level.
    run_phase(15'd0, 1'b0);
    set_level(15'd0);
    run_phase(15'd0, 1'b0);
    set_level(15'h7FFF);
    run_phase(15'h7FFF, 1'b0);
    set_level(15'd1);
    run_phase(15'd1, 1'b1);
    begin
      logic [P_W-1:0] lvl;
      lvl = P_W'($urandom_range(2, 4000));
      set_level(lvl);
      run_phase(lvl, 1'b0);
      set_level(THRESH_RESET);
      run_phase(THRESH_RESET, 1'b0);
      lvl = P_W'($urandom_range(4001, 32766));
      set_level(lvl);
      run_phase(lvl, 1'b0);
    end

    repeat (20) @(posedge clk);
    $display("sent %0d sample words, checked %0d results over %0d threshold writes",
             words_taken, words_checked, levels_used);
    $display("predicted %0d breath starts and %0d breath ends", breaths_started,
             breaths_ended);
    if (mismatch_count == 0 && words_waiting == 0) begin
      $display("breath_detect_integrator_top_tb OK");
    end else begin
      $display("breath_detect_integrator_top_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/bdi_pkg.sv
rtl/bdi_sqrt.sv
rtl/bdi_ctrl.sv
rtl/bdi_dp.sv
rtl/breath_detect_integrator_top.sv
test/breath_detect_integrator_checker.sv
test/breath_detect_integrator_top_tb.sv
